// ===== sv/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int INDEX_W = 13;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  localparam logic [15:0] ATTR_BITS  = 16'h0F00;

  localparam logic REG_SCREEN_COLS = 1'b0;
  localparam logic REG_SCREEN_ROWS = 1'b1;

  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET = 7'd25;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BS,
    OP_LF,
    OP_CR,
    OP_PUT,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         char_code;
    logic [INDEX_W-1:0] cell_index;
  } cmd_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL_PRE,
    ST_SCROLL,
    ST_PUT,
    ST_FIN
  } eng_state_t;

endpackage

// ===== sv/tcw_front.sv =====
`timescale 1ns / 1ps

module tcw_front import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [7:0]         char_code,
  input  logic [INDEX_W-1:0] cell_index,
  input  logic               engine_ready,
  output logic               head_valid,
  output cmd_item_t          head,
  input  logic               pop
);

  localparam logic [1:0] QueueFull = 2'd2;

  cmd_item_t  slots [2];
  cmd_item_t  item;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  // decode the command into an operation
  always_comb begin
    item.char_code  = char_code;
    item.cell_index = cell_index;
    unique case (cmd)
      CMD_PUT: begin
        priority case (char_code)
          CH_NUL:  item.op = OP_NONE;
          CH_BS:   item.op = OP_BS;
          CH_LF:   item.op = OP_LF;
          CH_CR:   item.op = OP_CR;
          default: item.op = OP_PUT;
        endcase
      end
      CMD_READ:  item.op = OP_READ;
      CMD_CLEAR: item.op = OP_CLEAR;
      default:   item.op = OP_NONE;
    endcase
  end

  assign in_ready   = engine_ready && (count != QueueFull);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

endmodule

// ===== sv/tcw_engine.sv =====
`timescale 1ns / 1ps

module tcw_engine import tcw_pkg::*; #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        head_valid,
  input  cmd_item_t   head,
  output logic        pop,
  output logic        engine_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] read_data,
  output logic [7:0]  cursor_col,
  output logic [5:0]  cursor_row,
  output logic        scrolled
);

  localparam int StoreCells = MAX_COLS * MAX_ROWS;
  localparam int AddrW      = (StoreCells > 1) ? $clog2(StoreCells) : 1;
  localparam int PtrW       = AddrW + 1;
  localparam int ColW       = $clog2(MAX_COLS + 1);
  localparam int RowW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RowCntW    = $clog2(MAX_ROWS + 1);
  localparam int WideW      = (PtrW > INDEX_W) ? PtrW : INDEX_W;

  logic [15:0] mem [StoreCells];
  logic [15:0] rd_data;

  logic [7:0]         screen_cols;
  logic [6:0]         screen_rows;
  logic [ColW-1:0]    eff_cols;
  logic [RowCntW-1:0] eff_rows;
  logic [PtrW-1:0]    area;
  logic [PtrW-1:0]    last_base;

  eng_state_t      state, state_next;
  logic [ColW-1:0] cx, cx_next;
  logic [RowW-1:0] cy, cy_next;
  logic [PtrW-1:0] ptr, ptr_next;
  logic            scr, scr_next;
  op_t             op_r;
  logic [7:0]      ch_r;
  logic            idx_ok_r;
  logic            latch;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;

  logic            out_load;
  logic [15:0]     ld_data;
  logic            go;
  logic [RowW-1:0] row_sel;
  logic [ColW-1:0] col_sel;
  logic [PtrW-1:0] cell_addr;

  logic [ColW-1:0]    cx_clamp;
  logic [RowW-1:0]    cy_clamp;
  logic [RowW-1:0]    bottom;
  logic [RowCntW-1:0] cy_inc;
  logic [RowCntW-1:0] put_row;
  logic               wrap;
  logic               put_over;
  logic               lf_over;
  logic               idx_ok;

  // register limits
  always_comb begin
    if (screen_cols == 8'd0) begin
      eff_cols = ColW'(1);
    end else if (int'(screen_cols) > MAX_COLS) begin
      eff_cols = ColW'(MAX_COLS);
    end else begin
      eff_cols = ColW'(screen_cols);
    end
    if (screen_rows == 7'd0) begin
      eff_rows = RowCntW'(1);
    end else if (int'(screen_rows) > MAX_ROWS) begin
      eff_rows = RowCntW'(MAX_ROWS);
    end else begin
      eff_rows = RowCntW'(screen_rows);
    end
  end

  always_ff @(posedge clk) begin
    area      <= PtrW'(eff_cols) * PtrW'(eff_rows);
    last_base <= PtrW'(eff_cols) * PtrW'(eff_rows - RowCntW'(1));
  end

  assign go        = !out_valid || out_ready;
  assign cell_addr = PtrW'(row_sel) * PtrW'(eff_cols) + PtrW'(col_sel);
  assign cx_clamp  = (cx > eff_cols) ? eff_cols : cx;
  assign bottom    = RowW'(eff_rows - RowCntW'(1));
  assign cy_clamp  = (RowCntW'(cy) >= eff_rows) ? bottom : cy;
  assign cy_inc    = RowCntW'(cy) + RowCntW'(1);
  assign wrap      = (cx >= eff_cols);
  assign put_row   = wrap ? cy_inc : RowCntW'(cy);
  assign put_over  = (put_row >= eff_rows);
  assign lf_over   = (cy_inc >= eff_rows);
  assign idx_ok    = WideW'(head.cell_index) < WideW'(StoreCells);

  assign engine_ready = (state != ST_INIT);

  always_comb begin
    state_next = state;
    cx_next    = cx;
    cy_next    = cy;
    ptr_next   = ptr;
    scr_next   = scr;
    pop        = 1'b0;
    latch      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cell_addr[AddrW-1:0];
    mem_wdata  = BLANK_CELL;
    rd_en      = 1'b0;
    rd_addr    = AddrW'(head.cell_index);
    out_load   = 1'b0;
    ld_data    = 16'h0000;
    row_sel    = cy;
    col_sel    = cx;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr[AddrW-1:0];
        ptr_next  = ptr + PtrW'(1);
        if (ptr == PtrW'(StoreCells - 1)) begin
          ptr_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          latch      = 1'b1;
          rd_en      = 1'b1;
          cx_next    = cx_clamp;
          cy_next    = cy_clamp;
          scr_next   = 1'b0;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (op_r)
          OP_BS: begin
            if (go) begin
              if (cx != '0) begin
                col_sel = cx - ColW'(1);
                mem_we  = 1'b1;
                cx_next = col_sel;
              end
              out_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          OP_CR: begin
            if (go) begin
              cx_next    = '0;
              out_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          OP_LF: begin
            if (lf_over) begin
              cx_next    = '0;
              cy_next    = bottom;
              scr_next   = 1'b1;
              state_next = ST_SCROLL_PRE;
            end else if (go) begin
              cx_next    = '0;
              cy_next    = RowW'(cy_inc);
              out_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          OP_PUT: begin
            if (put_over) begin
              cx_next    = '0;
              cy_next    = bottom;
              scr_next   = 1'b1;
              state_next = ST_SCROLL_PRE;
            end else if (go) begin
              row_sel    = RowW'(put_row);
              col_sel    = wrap ? '0 : cx;
              mem_we     = 1'b1;
              mem_wdata  = ATTR_BITS | {8'h00, ch_r};
              cx_next    = col_sel + ColW'(1);
              cy_next    = row_sel;
              out_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          OP_READ: begin
            if (go) begin
              ld_data    = idx_ok_r ? rd_data : 16'h0000;
              out_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          OP_CLEAR: begin
            cx_next    = '0;
            cy_next    = '0;
            ptr_next   = '0;
            state_next = ST_CLEAR;
          end
          default: begin
            if (go) begin
              out_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end
        endcase
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr[AddrW-1:0];
        ptr_next  = ptr + PtrW'(1);
        if (ptr == PtrW'(area - PtrW'(1))) begin
          ptr_next   = '0;
          state_next = ST_FIN;
        end
      end
      ST_SCROLL_PRE: begin
        rd_en      = 1'b1;
        rd_addr    = AddrW'(PtrW'(eff_cols));
        ptr_next   = '0;
        state_next = ST_SCROLL;
      end
      ST_SCROLL: begin
        // each cell above the last row takes the one a row below, read the cycle before; the last row is blanked
        mem_we    = 1'b1;
        mem_waddr = ptr[AddrW-1:0];
        mem_wdata = (ptr < last_base) ? rd_data : BLANK_CELL;
        rd_en     = 1'b1;
        rd_addr   = AddrW'(ptr + PtrW'(1) + PtrW'(eff_cols));
        ptr_next  = ptr + PtrW'(1);
        if (ptr == PtrW'(area - PtrW'(1))) begin
          ptr_next   = '0;
          state_next = (op_r == OP_PUT) ? ST_PUT : ST_FIN;
        end
      end
      ST_PUT: begin
        if (go) begin
          mem_we     = 1'b1;
          mem_wdata  = ATTR_BITS | {8'h00, ch_r};
          cx_next    = cx + ColW'(1);
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (go) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      cx          <= '0;
      cy          <= '0;
      ptr         <= '0;
      scr         <= 1'b0;
      out_valid   <= 1'b0;
      screen_cols <= COLS_RESET;
      screen_rows <= ROWS_RESET;
    end else begin
      state <= state_next;
      cx    <= cx_next;
      cy    <= cy_next;
      ptr   <= ptr_next;
      scr   <= scr_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SCREEN_COLS: screen_cols <= cfg_data;
          REG_SCREEN_ROWS: screen_rows <= cfg_data[6:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      op_r     <= head.op;
      ch_r     <= head.char_code;
      idx_ok_r <= idx_ok;
    end
    if (out_load) begin
      read_data  <= ld_data;
      cursor_col <= 8'(cx_next);
      cursor_row <= 6'(cy_next);
      scrolled   <= scr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/text_console_writer.sv =====
// channel  direction  handshake            word
// cmd      in         in_valid / in_ready   cmd, char_code, cell_index
// result   out        out_valid / out_ready read_data, cursor_col, cursor_row, scrolled
// config   in         cfg_write             cfg_index, cfg_data
//
// put, backspace, cr, lf and read: queue pop with cell read, then execute once the result register is free
// a scroll adds a pre-read of row 1, then rewrites all cols * rows cells, one cell moved per cycle
// clear blanks cols * rows cells, one cell blanked per cycle
// after reset a pass blanks all MAX_COLS * MAX_ROWS cells, one per cycle, in_ready low
// a two-word queue keeps in_ready up while a result waits in the output register
`timescale 1ns / 1ps

module text_console_writer import tcw_pkg::*; #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [7:0]         char_code,
  input  logic [INDEX_W-1:0] cell_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        read_data,
  output logic [7:0]         cursor_col,
  output logic [5:0]         cursor_row,
  output logic               scrolled
);

  logic      engine_ready;
  logic      head_valid;
  cmd_item_t head;
  logic      pop;

  tcw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .char_code    (char_code),
    .cell_index   (cell_index),
    .engine_ready (engine_ready),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop)
  );

  tcw_engine #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .engine_ready (engine_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .cursor_col   (cursor_col),
    .cursor_row   (cursor_row),
    .scrolled     (scrolled)
  );

endmodule

// ===== sv/tcw_checker.sv =====
`timescale 1ns / 1ps

module tcw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] read_data,
  input logic [7:0]  cursor_col,
  input logic [5:0]  cursor_row,
  input logic        scrolled
);

  // clearing pass holds off input right after reset
  a_init_blocks_input: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input open right after reset");

  a_reset_no_result: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(cursor_col)
      && $stable(cursor_row) && $stable(scrolled))
    else $error("stalled result word changed");

  // a scroll comes only from a put or lf
  a_scroll_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> read_data == 16'h0000)
    else $error("scroll word carries cell data");

  a_scroll_col: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> cursor_col <= 8'd1)
    else $error("cursor column too far right after scroll");

endmodule

bind text_console_writer tcw_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_data  (read_data),
  .cursor_col (cursor_col),
  .cursor_row (cursor_row),
  .scrolled   (scrolled)
);
